FILE: hw/rtl/rcs_pkg.sv
package rcs_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int CNT_W      = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT);
  localparam int SIZE_W     = 11;
  localparam int PIX_W      = 8;
  localparam int SUM_W      = 32;
  localparam int ACC_W      = 40;
  localparam int HEAD_W     = 9;
  localparam int POW_W      = 7;
  localparam int VAL_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 144;

  localparam int DIV_STEPS  = PIX_W;
  localparam int CMP_N      = 7;
  localparam int CMP_Y_FIRST = 4;
  localparam int STEP_W     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PIX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TOT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd3;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd320;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd240;

  localparam logic [POW_W-1:0] POWER_MID  = 7'd100;
  localparam logic [POW_W-1:0] POWER_DOWN = 7'd90;
  localparam logic [POW_W-1:0] POWER_UP   = 7'd110;
  localparam int HEAD_STEP = 10;
  localparam int HEAD_FULL = 360;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEC,
    ST_DIV,
    ST_ACC,
    ST_MODE,
    ST_MUL,
    ST_CMP,
    ST_STEER,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              load;
    logic              div_step;
    logic              acc;
    logic              mode;
    logic              mul;
    logic              cmp;
    logic              steer;
    logic              emit;
    logic [STEP_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic act;
    logic flat;
    logic need_cmp;
    logic out_free;
  } sts_t;

  // centroid test offsets: x +20, x -20, x +50, x -50, y +30, y -30, y 0
  function automatic logic signed [6:0] cmp_offset(input logic [STEP_W-1:0] idx);
    logic signed [6:0] r;
    case (idx)
      3'd0: r = 7'sd20;
      3'd1: r = -7'sd20;
      3'd2: r = 7'sd50;
      3'd3: r = -7'sd50;
      3'd4: r = 7'sd30;
      3'd5: r = -7'sd30;
      default: r = 7'sd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/rcs_datapath.sv
module rcs_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tuser,
  input  logic [rcs_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                             cfg_we,
  input  logic [rcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  rcs_pkg::cmd_t                    cmd,
  output rcs_pkg::sts_t                    sts,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [rcs_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                             m_tuser,
  output logic                             m_tlast
);
  import rcs_pkg::*;

  logic [PIX_W-1:0]  min_pix;
  logic [SUM_W-1:0]  min_tot;
  logic [SIZE_W-1:0] fw, fh;

  logic [SIZE_W-1:0] w, h;
  logic [CNT_W-1:0]  w_m1, h_m1, mx, my;

  logic [CNT_W-1:0]  col, row, x_r, y_r;
  logic              first_c, last_c, last_r, act_r;
  logic [HEAD_W-1:0] hd_r;

  logic [PIX_W-1:0]  ch_min [3];
  logic [PIX_W-1:0]  ch_max [3];
  logic [PIX_W-1:0]  ch     [3];
  logic [PIX_W-1:0]  rem    [3];
  logic [PIX_W-1:0]  qsh    [3];
  logic [PIX_W-1:0]  dv     [3];
  logic              flat_c;

  logic [SUM_W-1:0]  sum_value;
  logic [ACC_W-1:0]  sum_x, sum_y;
  logic              track, aligned;

  logic signed [10:0] vs;
  logic [PIX_W-1:0]   val_c, val_r;
  logic [PIX_W+CNT_W-1:0] px, py;

  logic               enter, trk_n, below;

  logic signed [11:0] op;
  logic signed [32:0] tot_s;
  logic signed [44:0] prod_c, prod;
  logic signed [45:0] cmpv;
  logic [CMP_N-1:0]   gt, lt;

  logic               nz;
  logic               xgt20, xlt20, xgtm20, xltm20, xgt50, xltm50;
  logic               ylt30, ygtm30, ypos, yneg, cx_ok, cy_ok;
  logic signed [10:0] hs, hw;

  logic               hv, pv, cen;
  logic [HEAD_W-1:0]  heading;
  logic [POW_W-1:0]   power;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      min_pix <= '0;
      min_tot <= '0;
      fw      <= WIDTH_RESET;
      fh      <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_PIX: min_pix <= cfg_data[PIX_W-1:0];
        CFG_MIN_TOT: min_tot <= cfg_data[SUM_W-1:0];
        CFG_WIDTH:   fw      <= cfg_data[SIZE_W-1:0];
        CFG_HEIGHT:  fh      <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fw < SIZE_W'(2))              w = SIZE_W'(2);
    else if (fw > SIZE_W'(MAX_WIDTH)) w = SIZE_W'(MAX_WIDTH);
    else                              w = fw;
    if (fh < SIZE_W'(2))               h = SIZE_W'(2);
    else if (fh > SIZE_W'(MAX_HEIGHT)) h = SIZE_W'(MAX_HEIGHT);
    else                               h = fh;
  end

  assign w_m1 = CNT_W'(w - SIZE_W'(1));
  assign h_m1 = CNT_W'(h - SIZE_W'(1));
  assign mx   = CNT_W'(w >> 1);
  assign my   = CNT_W'(h >> 1);

  assign first_c = (col == '0) && (row == '0);
  assign last_c  = (col >= w_m1) && (row >= h_m1);

  always_comb begin
    for (int k = 0; k < 3; k++) ch[k] = s_tdata[k*PIX_W +: PIX_W];
  end

  // position counters, shared by both passes
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cmd.load) begin
      if (col >= w_m1) begin
        col <= '0;
        row <= (row >= h_m1) ? '0 : row + CNT_W'(1);
      end else begin
        col <= col + CNT_W'(1);
      end
    end
  end

  // channel bounds
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        ch_min[k] <= '1;
        ch_max[k] <= '0;
      end
    end else if (cmd.load && !s_tuser) begin
      for (int k = 0; k < 3; k++) begin
        if (first_c) begin
          ch_min[k] <= ch[k];
          ch_max[k] <= ch[k];
        end else begin
          if (ch[k] < ch_min[k]) ch_min[k] <= ch[k];
          if (ch[k] > ch_max[k]) ch_max[k] <= ch[k];
        end
      end
    end
  end

  always_comb begin
    flat_c = 1'b0;
    for (int k = 0; k < 3; k++)
      if (ch_max[k] <= ch_min[k]) flat_c = 1'b1;
  end

  assign sts.flat = flat_c;

  // per-pixel registers and stretch dividers
  always_ff @(posedge clk) begin
    logic [PIX_W-1:0] cc, diff;
    logic [2*PIX_W-1:0] num;
    logic [PIX_W:0] trial;
    if (cmd.load) begin
      x_r    <= col;
      y_r    <= row;
      last_r <= last_c;
      act_r  <= s_tuser;
      hd_r   <= s_tdata[3*PIX_W +: HEAD_W];
      for (int k = 0; k < 3; k++) begin
        cc = ch[k];
        if (cc < ch_min[k]) cc = ch_min[k];
        if (cc > ch_max[k]) cc = ch_max[k];
        diff = cc - ch_min[k];
        num  = {diff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, diff};
        rem[k] <= num[2*PIX_W-1:PIX_W];
        qsh[k] <= num[PIX_W-1:0];
        dv[k]  <= ch_max[k] - ch_min[k];
      end
    end else if (cmd.div_step) begin
      for (int k = 0; k < 3; k++) begin
        trial = {rem[k], qsh[k][PIX_W-1]};
        if (trial >= {1'b0, dv[k]}) begin
          rem[k] <= PIX_W'(trial - {1'b0, dv[k]});
          qsh[k] <= {qsh[k][PIX_W-2:0], 1'b1};
        end else begin
          rem[k] <= trial[PIX_W-1:0];
          qsh[k] <= {qsh[k][PIX_W-2:0], 1'b0};
        end
      end
    end
  end

  // redness: 2r - g - b, capped and thresholded
  always_comb begin
    vs = $signed({2'b00, qsh[0], 1'b0}) - $signed({3'b000, qsh[1]})
       - $signed({3'b000, qsh[2]});
    if (vs > 11'sd255) vs = 11'sd255;
    if (vs < $signed({3'b000, min_pix})) vs = 11'sd0;
    val_c = vs[PIX_W-1:0];
  end

  assign px = val_c * x_r;
  assign py = val_c * y_r;

  // mode decision at frame end
  assign below = sum_value < min_tot;
  assign enter = !track && (sum_value > min_tot);
  assign trk_n = track || enter;
  assign sts.need_cmp = last_r && trk_n && !below && !aligned;
  assign sts.act = act_r;

  // centroid compares, one offset per pass through mul and cmp
  always_comb begin
    if (cmd.idx >= STEP_W'(CMP_Y_FIRST)) begin
      op   = $signed({2'b00, my}) + 12'(cmp_offset(cmd.idx));
      cmpv = $signed({6'b0, sum_y});
    end else begin
      op   = $signed({2'b00, mx}) + 12'(cmp_offset(cmd.idx));
      cmpv = $signed({6'b0, sum_x});
    end
  end

  assign tot_s  = $signed({1'b0, sum_value});
  assign prod_c = op * tot_s;

  always_ff @(posedge clk) begin
    if (cmd.mul) prod <= prod_c;
    if (cmd.cmp) begin
      gt[cmd.idx] <= cmpv > prod;
      lt[cmd.idx] <= cmpv < prod;
    end
  end

  assign nz     = sum_value != '0;
  assign xgt20  = nz && gt[0];
  assign xlt20  = nz && lt[0];
  assign xgtm20 = nz && gt[1];
  assign xltm20 = nz && lt[1];
  assign xgt50  = nz && gt[2];
  assign xltm50 = nz && lt[3];
  assign ylt30  = nz && lt[4];
  assign ygtm30 = nz && gt[5];
  assign ypos   = nz && gt[6];
  assign yneg   = nz && lt[6];
  assign cx_ok  = xlt20 && xgtm20;
  assign cy_ok  = ylt30 && ygtm30;

  always_comb begin
    hs = $signed({2'b00, hd_r});
    if (xgt20)  hs = hs + 11'(HEAD_STEP);
    if (xltm20) hs = hs - 11'(HEAD_STEP);
    if (xgt50)  hs = hs + 11'(HEAD_STEP);
    if (xltm50) hs = hs - 11'(HEAD_STEP);
    hw = hs;
    if (hw > 11'(HEAD_FULL)) hw = hw - 11'(HEAD_FULL);
    if (hw < 11'sd0)         hw = hw + 11'(HEAD_FULL);
  end

  // accumulators, mode and commands
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_value <= '0;
      sum_x     <= '0;
      sum_y     <= '0;
      track     <= 1'b0;
      aligned   <= 1'b0;
    end else if (cmd.load && s_tuser && first_c) begin
      sum_value <= '0;
      sum_x     <= '0;
      sum_y     <= '0;
    end else if (cmd.acc) begin
      sum_value <= sum_value + SUM_W'(val_c);
      sum_x     <= sum_x + ACC_W'(px);
      sum_y     <= sum_y + ACC_W'(py);
    end else if (cmd.mode && last_r) begin
      track <= trk_n && !below;
      if (trk_n && below) aligned <= 1'b0;
    end else if (cmd.steer && cx_ok && cy_ok) begin
      aligned <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r   <= '0;
      hv      <= 1'b0;
      pv      <= 1'b0;
      cen     <= 1'b0;
      heading <= '0;
      power   <= POWER_MID;
    end else if (cmd.acc) begin
      val_r <= val_c;
    end else if (cmd.mode) begin
      if (last_r && trk_n && !below && aligned) pv <= 1'b1;
    end else if (cmd.steer) begin
      hv      <= 1'b1;
      heading <= hw[HEAD_W-1:0];
      cen     <= cx_ok && cy_ok;
      if (!(cx_ok && cy_ok)) begin
        pv <= 1'b1;
        if (!cy_ok && ypos)      power <= POWER_DOWN;
        else if (!cy_ok && yneg) power <= POWER_UP;
        else                     power <= POWER_MID;
      end
    end
  end

  // output register
  assign sts.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.emit) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {2'b00, cen, power, pv, heading, hv, track, sum_y, sum_x, sum_value,
                  {(VAL_W-PIX_W){1'b0}}, val_r};
      m_tuser <= flat_c;
      m_tlast <= last_r;
    end
  end

endmodule

FILE: hw/rtl/rcs_ctrl.sv
module rcs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  rcs_pkg::sts_t sts,
  output rcs_pkg::cmd_t cmd
);
  import rcs_pkg::*;

  state_t            state, state_next;
  logic [STEP_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_DEC;
      ST_DEC: begin
        cnt_next   = '0;
        state_next = (sts.act && !sts.flat) ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        if (cnt == STEP_W'(DIV_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = ST_ACC;
        end else begin
          cnt_next = cnt + STEP_W'(1);
        end
      end
      ST_ACC: state_next = ST_MODE;
      ST_MODE: begin
        cnt_next   = '0;
        state_next = sts.need_cmp ? ST_MUL : ST_FIN;
      end
      ST_MUL: state_next = ST_CMP;
      ST_CMP: begin
        if (cnt == STEP_W'(CMP_N - 1)) begin
          state_next = ST_STEER;
        end else begin
          cnt_next   = cnt + STEP_W'(1);
          state_next = ST_MUL;
        end
      end
      ST_STEER: state_next = ST_FIN;
      ST_FIN: if (sts.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.idx  = cnt;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_DIV:   cmd.div_step = 1'b1;
      ST_ACC:   cmd.acc = 1'b1;
      ST_MODE:  cmd.mode = 1'b1;
      ST_MUL:   cmd.mul = 1'b1;
      ST_CMP:   cmd.cmp = 1'b1;
      ST_STEER: cmd.steer = 1'b1;
      ST_FIN:   cmd.emit = sts.out_free;
      default: ;
    endcase
  end

  a_load_dec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_DEC) else $error("load not followed by decode");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && cnt == STEP_W'(DIV_STEPS - 1)) |=> state == ST_ACC)
    else $error("divider step count wrong");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.div_step, cmd.acc, cmd.mode, cmd.mul, cmd.cmp,
              cmd.steer, cmd.emit})) else $error("overlapping commands");
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> state == ST_IDLE) else $error("emit without return to idle");

endmodule

FILE: hw/rtl/redness_centroid_steering_top.sv
// channel  dir  fields (tdata from bit 0 up)
// s_*      in   tdata: red[7:0] green[15:8] blue[23:16] heading_now[32:24]; tuser: action
// m_*      out  tdata: pixel_value total_intensity weighted_x weighted_y tracking
//               heading_valid desired_heading power_valid desired_power centered;
//               tuser: rejected; tlast: frame_end
// cfg_*    in   index 0 pixel floor, 1 total floor, 2 width, 3 height
//
// statistics pixels and rejected compute pixels skip the dividers; a compute pixel runs
// the 8 steps of the three shared-in-time restoring dividers
// steering at frame end passes 7 offsets through one 12x33 multiplier and compare
// rst is synchronous; no clearing pass
// one item at a time; a new beat is taken while the previous result waits in m_*
module redness_centroid_steering_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [rcs_pkg::IN_DATA_W-1:0]    s_tdata,   // red, green, blue, heading_now
  input  logic                             s_tuser,   // action
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // pixel_value[9:0] total_intensity[41:10] weighted_x[81:42] weighted_y[121:82]
  // tracking[122] heading_valid[123] desired_heading[132:124] power_valid[133]
  // desired_power[140:134] centered[141]
  output logic [rcs_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                             m_tuser,   // rejected
  output logic                             m_tlast,
  input  logic                             cfg_we,
  input  logic [rcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rcs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rcs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

FILE: dv/tb_redness_centroid_steering_top.sv
`timescale 1ns / 100ps

module tb_redness_centroid_steering_top;
  import rcs_pkg::*;

  localparam logic ACT_STATS   = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;
  localparam int   CYCLE_LIMIT = 1500000;
  localparam int   IDLE_CYCLES = 40;

  typedef enum int {FR_BLOB, FR_RANDOM, FR_FLAT, FR_NOISE, FR_NO_STATS} frame_kind_t;

  typedef struct packed {
    logic              act;
    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  blue;
    logic [HEAD_W-1:0] heading;
  } pixel_t;

  typedef struct {
    logic [VAL_W-1:0]  value;
    logic              last;
    logic              rejected;
    logic [SUM_W-1:0]  total;
    logic [ACC_W-1:0]  wx;
    logic [ACC_W-1:0]  wy;
    logic              trk;
    logic              hv;
    logic [HEAD_W-1:0] head;
    logic              pv;
    logic [POW_W-1:0]  power;
    logic              cen;
  } steer_beat_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  redness_centroid_steering_top u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // register copies
  logic [7:0]        min_pix_reg = 8'd0;
  logic [31:0]       min_tot_reg = 32'd0;
  logic [SIZE_W-1:0] width_reg = WIDTH_RESET;
  logic [SIZE_W-1:0] height_reg = HEIGHT_RESET;

  // block state copy
  logic [7:0]       chan_lo [3] = '{8'd255, 8'd255, 8'd255};
  logic [7:0]       chan_hi [3] = '{8'd0, 8'd0, 8'd0};
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;
  logic [SUM_W-1:0] redness_sum = '0;
  logic [ACC_W-1:0] col_moment = '0;
  logic [ACC_W-1:0] row_moment = '0;
  bit               in_track = 0;
  bit               is_aligned = 0;

  pixel_t      pending_pixels[$];
  steer_beat_t expected_beats[$];
  pixel_t      cur_pixel;
  int          taken_count = 0;
  int          errors = 0;
  int          cycles = 0;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned maxv);
    if (v < 2) return 2;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int unsigned stretch_chan(int unsigned c, int unsigned lo, int unsigned hi);
    if (c < lo) c = lo;
    if (c > hi) c = hi;
    return (c - lo) * 255 / (hi - lo);
  endfunction

  task automatic predict_beat(input pixel_t p);
    int unsigned w, h, x, y, r, g, b;
    bit first, last, flat, cx_ok, cy_ok, nz;
    int v, heading;
    longint t, cx, cy, mx, my;
    steer_beat_t e;
    logic [7:0] ch [3];
    w = clamp_size(width_reg, MAX_WIDTH);
    h = clamp_size(height_reg, MAX_HEIGHT);
    x = col_pos;
    y = row_pos;
    first = (x == 0 && y == 0);
    last = (x >= w - 1 && y >= h - 1);
    ch[0] = p.red;
    ch[1] = p.green;
    ch[2] = p.blue;
    e.value = '0;
    e.hv = 0;
    e.head = '0;
    e.pv = 0;
    e.power = POWER_MID;
    e.cen = 0;
    if (x >= w - 1) begin
      col_pos = 0;
      row_pos = (y >= h - 1) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
    if (p.act == ACT_STATS) begin
      for (int k = 0; k < 3; k++) begin
        if (first) begin
          chan_lo[k] = 8'd255;
          chan_hi[k] = 8'd0;
        end
        if (ch[k] < chan_lo[k]) chan_lo[k] = ch[k];
        if (ch[k] > chan_hi[k]) chan_hi[k] = ch[k];
      end
    end
    flat = 0;
    for (int k = 0; k < 3; k++)
      if (chan_hi[k] <= chan_lo[k]) flat = 1;
    if (p.act == ACT_COMPUTE) begin
      if (first) begin
        redness_sum = '0;
        col_moment = '0;
        row_moment = '0;
      end
      if (!flat) begin
        r = stretch_chan(ch[0], chan_lo[0], chan_hi[0]);
        g = stretch_chan(ch[1], chan_lo[1], chan_hi[1]);
        b = stretch_chan(ch[2], chan_lo[2], chan_hi[2]);
        v = 2 * int'(r) - int'(g) - int'(b);
        if (v > 255) v = 255;
        if (v < int'(min_pix_reg)) v = 0;
        e.value = v[VAL_W-1:0];
        redness_sum = redness_sum + v;
        col_moment = col_moment + ACC_W'(v) * ACC_W'(x);
        row_moment = row_moment + ACC_W'(v) * ACC_W'(y);
      end
      if (last && !flat) begin
        if (!in_track && redness_sum > min_tot_reg) in_track = 1;
        if (in_track) begin
          if (redness_sum < min_tot_reg) begin
            in_track = 0;
            is_aligned = 0;
          end else if (is_aligned) begin
            e.pv = 1;
          end else begin
            t = longint'(redness_sum);
            cx = longint'(col_moment);
            cy = longint'(row_moment);
            mx = longint'(w / 2);
            my = longint'(h / 2);
            nz = (redness_sum != 0);
            heading = int'(p.heading);
            if (nz && cx > (mx + 20) * t) heading += HEAD_STEP;
            if (nz && cx < (mx - 20) * t) heading -= HEAD_STEP;
            if (nz && cx > (mx + 50) * t) heading += HEAD_STEP;
            if (nz && cx < (mx - 50) * t) heading -= HEAD_STEP;
            if (heading > HEAD_FULL) heading -= HEAD_FULL;
            if (heading < 0) heading += HEAD_FULL;
            cx_ok = nz && cx < (mx + 20) * t && cx > (mx - 20) * t;
            cy_ok = nz && cy < (my + 30) * t && cy > (my - 30) * t;
            e.hv = 1;
            e.head = heading[HEAD_W-1:0];
            e.cen = cx_ok && cy_ok;
            if (e.cen) begin
              is_aligned = 1;
            end else begin
              e.pv = 1;
              if (!cy_ok && nz && cy > my * t) e.power = POWER_DOWN;
              else if (!cy_ok && nz && cy < my * t) e.power = POWER_UP;
            end
          end
        end
      end
    end
    e.last = last;
    e.rejected = flat;
    e.total = redness_sum;
    e.wx = col_moment;
    e.wy = row_moment;
    e.trk = in_track;
    expected_beats = {expected_beats, e};
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, exp);
    errors++;
  endtask

  task automatic check_beat();
    steer_beat_t e;
    if (expected_beats.size() == 0) begin
      report("unexpected beat", m_tdata[63:0], 64'd0);
      return;
    end
    e = expected_beats.pop_front();
    if (m_tdata[9:0] !== e.value) report("pixel_value", m_tdata[9:0], e.value);
    if (m_tlast !== e.last) report("frame_end", m_tlast, e.last);
    if (m_tuser !== e.rejected) report("rejected", m_tuser, e.rejected);
    if (m_tdata[41:10] !== e.total) report("total_intensity", m_tdata[41:10], e.total);
    if (m_tdata[81:42] !== e.wx) report("weighted_x", m_tdata[81:42], e.wx);
    if (m_tdata[121:82] !== e.wy) report("weighted_y", m_tdata[121:82], e.wy);
    if (m_tdata[122] !== e.trk) report("tracking", m_tdata[122], e.trk);
    if (m_tdata[123] !== e.hv) report("heading_valid", m_tdata[123], e.hv);
    if (m_tdata[132:124] !== e.head) report("desired_heading", m_tdata[132:124], e.head);
    if (m_tdata[133] !== e.pv) report("power_valid", m_tdata[133], e.pv);
    if (m_tdata[140:134] !== e.power) report("desired_power", m_tdata[140:134], e.power);
    if (m_tdata[141] !== e.cen) report("centered", m_tdata[141], e.cen);
  endtask

  // monitor: input acceptance feeds the predictor, output beats are checked
  always @(posedge clk) begin
    cycles++;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_beat(cur_pixel);
        taken_count++;
      end
      if (m_tvalid && m_tready) check_beat();
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_redness_centroid_steering_top failed");
      $finish;
    end
  end

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  int handled_count = 0;
  always @(negedge clk) begin
    logic   nv;
    pixel_t np;
    nv = s_tvalid && (taken_count == handled_count);
    handled_count = taken_count;
    if (!nv && !rst) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_pixels.size() > 0) begin
        np = pending_pixels.pop_front();
        cur_pixel = np;
        s_tdata <= {7'd0, np.heading, np.blue, np.green, np.red};
        s_tuser <= np.act;
        nv = 1;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
          gap_left = $urandom_range(0, 5);
        end else begin
          burst_left--;
        end
      end
    end
    s_tvalid <= nv;
  end

  // receiver stall pattern
  int ready_mode = 0;
  int mode_left = 0;
  int ready_phase = 0;
  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(50, 300);
    end
    mode_left--;
    ready_phase++;
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= (ready_phase % 4 == 0);
      default: m_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // stimulus side position tracker
  int unsigned gen_col = 0;
  int unsigned gen_row = 0;
  int random_count = 0;

  task automatic add_pixel(input logic act, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic [8:0] hd);
    int unsigned w, h;
    pixel_t p;
    w = clamp_size(width_reg, MAX_WIDTH);
    h = clamp_size(height_reg, MAX_HEIGHT);
    p.act = act;
    p.red = r;
    p.green = g;
    p.blue = b;
    p.heading = hd;
    pending_pixels = {pending_pixels, p};
    if (gen_col >= w - 1) begin
      gen_col = 0;
      gen_row = (gen_row >= h - 1) ? 0 : gen_row + 1;
    end else begin
      gen_col++;
    end
  endtask

  function automatic logic [8:0] pick_heading();
    case ($urandom_range(0, 9))
      0: return 9'd0;
      1: return 9'd360;
      2: return 9'($urandom_range(361, 511));
      default: return 9'($urandom_range(0, 360));
    endcase
  endfunction

  task automatic add_noise();
    add_pixel(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), pick_heading());
  endtask

  task automatic realign();
    while (gen_col != 0 || gen_row != 0) add_noise();
  endtask

  task automatic add_frame(input frame_kind_t kind);
    int unsigned n, bx, by, d;
    logic [8:0] hd;
    logic [7:0] fixed_green;
    n = clamp_size(width_reg, MAX_WIDTH) * clamp_size(height_reg, MAX_HEIGHT);
    bx = $urandom_range(0, clamp_size(width_reg, MAX_WIDTH) - 1);
    by = $urandom_range(0, clamp_size(height_reg, MAX_HEIGHT) - 1);
    fixed_green = 8'($urandom_range(0, 255));
    hd = pick_heading();
    for (int pass = 0; pass < 2; pass++) begin
      for (int unsigned i = 0; i < n; i++) begin
        d = ((gen_col > bx) ? gen_col - bx : bx - gen_col) +
            ((gen_row > by) ? gen_row - by : by - gen_row);
        case (kind)
          FR_BLOB:
            if (d < 3)
              add_pixel(1'(pass), 8'($urandom_range(200, 255)), 8'($urandom_range(0, 60)),
                        8'($urandom_range(0, 60)), hd);
            else
              add_pixel(1'(pass), 8'($urandom_range(0, 80)), 8'($urandom_range(50, 255)),
                        8'($urandom_range(50, 255)), hd);
          FR_FLAT:
            add_pixel(1'(pass), 8'($urandom_range(0, 255)), fixed_green,
                      8'($urandom_range(0, 255)), hd);
          FR_NOISE: add_noise();
          FR_NO_STATS:
            add_pixel(ACT_COMPUTE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), hd);
          default:
            add_pixel(1'(pass), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), hd);
        endcase
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_pixels.size() != 0 || s_tvalid || expected_beats.size() != 0)
      @(posedge clk);
    // extra idle margin after the last checked beat
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_MIN_PIX: min_pix_reg = value[7:0];
      CFG_MIN_TOT: min_tot_reg = value;
      CFG_WIDTH:   width_reg = value[SIZE_W-1:0];
      default:     height_reg = value[SIZE_W-1:0];
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [31:0] mp, input logic [31:0] mt,
                           input logic [31:0] w, input logic [31:0] h);
    wait_idle();
    write_reg(CFG_MIN_PIX, mp);
    write_reg(CFG_MIN_TOT, mt);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    end_writes();
  endtask

  function automatic logic [31:0] pick_min_total();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 3000);
    endcase
  endfunction

  initial begin
    frame_kind_t kind;
    int k;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sizes below the floor clamp to 2x2
    write_all(0, 0, 0, 1);
    add_frame(FR_NO_STATS);
    // full-range stats, then compute pixels over that range
    add_pixel(ACT_STATS, 8'd0, 8'd255, 8'd0, 9'd0);
    add_pixel(ACT_STATS, 8'd255, 8'd0, 8'd255, 9'd511);
    add_pixel(ACT_STATS, 8'd128, 8'd128, 8'd128, 9'd0);
    add_pixel(ACT_STATS, 8'd60, 8'd200, 8'd60, 9'd360);
    add_pixel(ACT_COMPUTE, 8'd255, 8'd0, 8'd0, 9'd360);
    add_pixel(ACT_COMPUTE, 8'd0, 8'd255, 8'd255, 9'd360);
    add_pixel(ACT_COMPUTE, 8'd255, 8'd255, 8'd0, 9'd360);
    add_pixel(ACT_COMPUTE, 8'd200, 8'd10, 8'd30, 9'd360);
    add_frame(FR_FLAT);
    write_all(255, 32'hFFFF_FFFF, 2, 2);
    add_frame(FR_BLOB);

    // wide and tall frames to drive heading and power steering
    write_all(0, 0, $urandom_range(106, 112), 2);
    add_frame(FR_BLOB);
    write_all(20, 0, 2, $urandom_range(64, 70));
    add_frame(FR_BLOB);

    // size extremes, then shrink mid-frame
    write_all(0, 0, 2047, 2047);
    repeat (6) add_noise();
    write_all(0, 0, 1024, 1024);
    repeat (3) add_noise();
    write_all(0, 0, 3, 3);
    realign();

    while (random_count < 120) begin
      k = pending_pixels.size();
      write_all($urandom_range(0, 3) == 0 ? 255 : $urandom_range(0, 120),
                pick_min_total(),
                $urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 6),
                $urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 4));
      realign();
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 19))
          0, 1:    kind = FR_FLAT;
          2, 3, 4: kind = FR_NOISE;
          5:       kind = FR_NO_STATS;
          6, 7, 8, 9, 10: kind = FR_RANDOM;
          default: kind = FR_BLOB;
        endcase
        add_frame(kind);
      end
      random_count += pending_pixels.size() - k;
    end

    wait_idle();
    if (errors == 0) begin
      $display("tb_redness_centroid_steering_top passed");
    end else begin
      $display("tb_redness_centroid_steering_top failed");
    end
    $finish;
  end

endmodule
